// ===== src/cesd_pkg.sv =====
// Package: shared types, constants and character helpers for the escape decoder.
package cesd_pkg;

    // Width of characters and decoded bytes.
    localparam int CHAR_W = 8;
    // Width of the running byte count.
    localparam int COUNT_W = 16;
    // Results one character can cause.
    localparam int MAX_RES = 3;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_NUM_W = $clog2(MAX_RES + 1);

    // Longest text the count follows; the count saturates at the smaller of this and 16 bits.
    localparam longint unsigned MAX_TEXT_LEN = 64'd65535;
    localparam longint unsigned COUNT_FULL   = (64'd1 << COUNT_W) - 64'd1;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        COUNT_W'((MAX_TEXT_LEN > COUNT_FULL) ? COUNT_FULL : MAX_TEXT_LEN);

    // Escape decoder mode; unused codes behave as idle.
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_OCT1 = 3'd2,
        MODE_OCT2 = 3'd3,
        MODE_HEX0 = 3'd4,
        MODE_HEX1 = 3'd5
    } t_mode;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [COUNT_W-1:0] t_count;

    // Characters with a meaning of their own.
    localparam t_char CH_BSLASH = 8'h5C;
    localparam t_char CH_X      = 8'h78;
    localparam t_char CH_A      = 8'h61;
    localparam t_char CH_B      = 8'h62;
    localparam t_char CH_E      = 8'h65;
    localparam t_char CH_F      = 8'h66;
    localparam t_char CH_N      = 8'h6E;
    localparam t_char CH_R      = 8'h72;
    localparam t_char CH_T      = 8'h74;
    localparam t_char CH_V      = 8'h76;
    localparam t_char CH_0      = 8'h30;
    localparam t_char CH_7      = 8'h37;
    localparam t_char CH_9      = 8'h39;
    localparam t_char CH_UA     = 8'h41;
    localparam t_char CH_UF     = 8'h46;

    // Bytes the named escapes stand for.
    localparam t_char BYTE_BEL = 8'd7;
    localparam t_char BYTE_BS  = 8'd8;
    localparam t_char BYTE_ESC = 8'd27;
    localparam t_char BYTE_FF  = 8'd12;
    localparam t_char BYTE_LF  = 8'd10;
    localparam t_char BYTE_CR  = 8'd13;
    localparam t_char BYTE_TAB = 8'd9;
    localparam t_char BYTE_VT  = 8'd11;

    function automatic logic is_octal(input t_char c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    function automatic logic is_hex(input t_char c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // Value of a hex digit; zero for anything else.
    function automatic logic [3:0] hex_val(input t_char c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = 4'(c - CH_0);
        end else if ((c >= CH_A) && (c <= CH_F)) begin
            v = 4'(c - CH_A + 8'd10);
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            v = 4'(c - CH_UA + 8'd10);
        end
        return v;
    endfunction

    // Clamp a collected octal value to one byte.
    function automatic t_char sat_octal(input logic [8:0] v);
        return (v > 9'd255) ? 8'hFF : v[7:0];
    endfunction

    // Add a small step to the count, stopping at the limit.
    function automatic t_count sat_add(input t_count cnt, input logic [RES_NUM_W-1:0] step);
        logic [COUNT_W:0] sum;
        sum = {1'b0, cnt} + (COUNT_W + 1)'(step);
        return (sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : sum[COUNT_W-1:0];
    endfunction

endpackage

// ===== src/cesd_in_if.sv =====
// Interface: input character channel of the escape decoder.
interface cesd_in_if
    import cesd_pkg::*;
();
    logic  valid;
    logic  ready;
    t_char text_char;
    logic  end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

// ===== src/cesd_out_if.sv =====
// Interface: decoded byte channel of the escape decoder.
interface cesd_out_if
    import cesd_pkg::*;
();
    logic   valid;
    logic   ready;
    t_char  out_byte;
    logic   has_byte;
    logic   run_last;
    logic   text_end;
    t_count out_count;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output text_end, output out_count, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input text_end, input out_count, output ready);
endinterface

// ===== src/c_escape_sequence_decoder_top.sv =====
// Top level: C-style backslash escape decoder with a result buffer.
//
// One character enters per transaction and is decoded in the same cycle against the
// escape state; the up to three bytes it completes are loaded into a result buffer that
// hands them out one per cycle while the output is ready. A character that yields at most
// one result is taken every cycle while the output is ready; one that yields several holds
// the output until all have left, and the next character is taken in the cycle the last
// of them leaves. Each result carries a saturating count of the bytes decoded so far in
// the current text; end_of_text flushes any pending escape, returns one bare end marker
// when nothing else results, and clears the state for the next text.
module c_escape_sequence_decoder_top
    import cesd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cesd_in_if.sink       i_in,
    cesd_out_if.source    o_out
);

    // Escape state
    t_mode       r_mode, n_mode;
    logic [8:0]  r_oct, n_oct;
    t_char       r_held, n_held;
    t_count      r_cnt, n_cnt;

    // Result buffer
    t_char                r_byte [MAX_RES];
    t_count               r_rcnt [MAX_RES];
    logic [RES_NUM_W-1:0] r_num;
    logic [RES_IDX_W-1:0] r_idx;
    logic                 r_has;
    logic                 r_end;

    // Decode results
    t_char                e_byte [MAX_RES];
    t_count               e_cnt  [MAX_RES];
    logic [RES_NUM_W-1:0] e_n;
    logic [RES_NUM_W-1:0] e_num;
    logic                 e_has;

    logic  in_fire;
    logic  out_fire;
    logic  run_last;
    t_char c;
    logic  last;

    assign c    = i_in.text_char;
    assign last = i_in.end_of_text;

    // Decode one character against the escape state
    always_comb begin
        logic plain;
        n_mode = r_mode;
        n_oct  = r_oct;
        n_held = r_held;
        plain  = 1'b0;
        e_n    = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            e_byte[k] = '0;
        end

        case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_IDLE;
                case (c)
                    CH_A:    begin e_byte[e_n] = BYTE_BEL; e_n = e_n + 1'b1; end
                    CH_B:    begin e_byte[e_n] = BYTE_BS;  e_n = e_n + 1'b1; end
                    CH_E:    begin e_byte[e_n] = BYTE_ESC; e_n = e_n + 1'b1; end
                    CH_F:    begin e_byte[e_n] = BYTE_FF;  e_n = e_n + 1'b1; end
                    CH_N:    begin e_byte[e_n] = BYTE_LF;  e_n = e_n + 1'b1; end
                    CH_R:    begin e_byte[e_n] = BYTE_CR;  e_n = e_n + 1'b1; end
                    CH_T:    begin e_byte[e_n] = BYTE_TAB; e_n = e_n + 1'b1; end
                    CH_V:    begin e_byte[e_n] = BYTE_VT;  e_n = e_n + 1'b1; end
                    CH_X:    n_mode = MODE_HEX0;
                    default: begin
                        if (is_octal(c)) begin
                            n_oct  = 9'(c - CH_0);
                            n_mode = MODE_OCT1;
                        end else begin
                            e_byte[e_n] = c;
                            e_n = e_n + 1'b1;
                        end
                    end
                endcase
            end
            MODE_OCT1, MODE_OCT2: begin
                if (is_octal(c)) begin
                    n_oct = {r_oct[5:0], 3'b000} + 9'(c - CH_0);
                    if (r_mode == MODE_OCT1) begin
                        n_mode = MODE_OCT2;
                    end else begin
                        e_byte[e_n] = sat_octal(n_oct);
                        e_n    = e_n + 1'b1;
                        n_oct  = '0;
                        n_mode = MODE_IDLE;
                    end
                end else begin
                    e_byte[e_n] = sat_octal(r_oct);
                    e_n   = e_n + 1'b1;
                    n_oct = '0;
                    plain = 1'b1;
                end
            end
            MODE_HEX0: begin
                if (is_hex(c)) begin
                    n_held = c;
                    n_mode = MODE_HEX1;
                end else begin
                    e_byte[e_n] = CH_X;
                    e_n   = e_n + 1'b1;
                    plain = 1'b1;
                end
            end
            MODE_HEX1: begin
                if (is_hex(c)) begin
                    e_byte[e_n] = {hex_val(r_held), hex_val(c)};
                    e_n    = e_n + 1'b1;
                    n_mode = MODE_IDLE;
                end else begin
                    e_byte[e_n] = CH_X;
                    e_n = e_n + 1'b1;
                    e_byte[e_n] = r_held;
                    e_n   = e_n + 1'b1;
                    plain = 1'b1;
                end
                n_held = '0;
            end
            default: plain = 1'b1;
        endcase

        // Character outside an escape
        if (plain) begin
            if (c == CH_BSLASH) begin
                n_mode = MODE_ESC;
            end else begin
                n_mode = MODE_IDLE;
                e_byte[e_n] = c;
                e_n = e_n + 1'b1;
            end
        end

        // Flush a pending escape at end of text; a lone backslash is dropped
        if (last) begin
            case (n_mode)
                MODE_OCT1, MODE_OCT2: begin
                    e_byte[e_n] = sat_octal(n_oct);
                    e_n = e_n + 1'b1;
                end
                MODE_HEX0: begin
                    e_byte[e_n] = CH_X;
                    e_n = e_n + 1'b1;
                end
                MODE_HEX1: begin
                    e_byte[e_n] = CH_X;
                    e_n = e_n + 1'b1;
                    e_byte[e_n] = n_held;
                    e_n = e_n + 1'b1;
                end
                default: ;
            endcase
        end

        // Count after each byte
        for (int k = 0; k < MAX_RES; k++) begin
            e_cnt[k] = sat_add(r_cnt, RES_NUM_W'(k + 1));
        end
        e_num = e_n;
        e_has = 1'b1;
        n_cnt = (e_n == '0) ? r_cnt : e_cnt[RES_IDX_W'(e_n - 1'b1)];

        // Bare end marker when the last character yields nothing
        if (last && (e_n == '0)) begin
            e_cnt[0] = r_cnt;
            e_num    = RES_NUM_W'(1);
            e_has    = 1'b0;
        end

        // Start the next text from reset state
        if (last) begin
            n_mode = MODE_IDLE;
            n_oct  = '0;
            n_held = '0;
            n_cnt  = '0;
        end
    end

    // Handshakes
    assign run_last  = (r_num != '0) && (RES_NUM_W'(r_idx) == r_num - 1'b1);
    assign o_out.valid = (r_num != '0);
    assign out_fire  = o_out.valid && o_out.ready;
    assign i_in.ready = (r_num == '0) || (o_out.ready && run_last);
    assign in_fire   = i_in.valid && i_in.ready;

    // Present the current buffered result
    assign o_out.out_byte  = r_byte[r_idx];
    assign o_out.out_count = r_rcnt[r_idx];
    assign o_out.has_byte  = r_has;
    assign o_out.run_last  = run_last;
    assign o_out.text_end  = r_end && run_last;

    // Advance escape state on each accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_oct  <= '0;
            r_held <= '0;
            r_cnt  <= '0;
        end else if (in_fire) begin
            r_mode <= n_mode;
            r_oct  <= n_oct;
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

    // Load or drain the result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= '0;
            r_idx <= '0;
        end else if (in_fire) begin
            r_num <= e_num;
            r_idx <= '0;
        end else if (out_fire) begin
            if (run_last) begin
                r_num <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_byte[k] <= e_byte[k];
                r_rcnt[k] <= e_cnt[k];
            end
            r_has <= e_has;
            r_end <= last;
        end
    end

endmodule
